>>> rtl/wsd_pkg.sv
package wsd_pkg;

  // Largest accepted payload length is 2^min(LengthWidth,32) - 1 bytes.
  localparam int unsigned LengthWidth = 32;
  localparam int unsigned LenCheckShift = (LengthWidth >= 32) ? 32 : LengthWidth;

  localparam logic [7:0] FirstText   = 8'h81;
  localparam logic [7:0] FirstBinary = 8'h82;
  localparam logic [6:0] Len16Code   = 7'd126;
  localparam logic [6:0] Len64Code   = 7'd127;

  // header byte counts before the mask key
  localparam logic [3:0] HeadShort = 4'd2;
  localparam logic [3:0] Head16    = 4'd4;
  localparam logic [3:0] Head64    = 4'd10;
  localparam logic [3:0] Ext64Len  = 4'd8;
  localparam logic [3:0] UpperLen  = 4'd4;
  localparam logic [3:0] MaskBytes = 4'd4;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_LEN,
    PH_EXT,
    PH_MASK,
    PH_PAYLOAD
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_HEADER    = 2'd1,
    KIND_BAD_FIRST = 2'd2,
    KIND_TOO_LONG  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [31:0] payload_length;
    logic [3:0]  header_size;
    logic [32:0] packet_size;
    logic        is_binary;
    logic        last;
  } res_t;

endpackage

>>> rtl/wsd_in_reg.sv
module wsd_in_reg import wsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  output logic       in_stall_o,
  input  logic       take_i,
  output logic       vld_o,
  output logic [7:0] byte_o
);

  logic       vld_q, vld_d;
  logic [7:0] byte_q, byte_d;
  logic       load;

  assign in_stall_o = vld_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    vld_d  = load ? 1'b1 : (take_i ? 1'b0 : vld_q);
    byte_d = load ? in_byte_i : byte_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign vld_o  = vld_q;
  assign byte_o = byte_q;

endmodule

>>> rtl/wsd_core.sv
module wsd_core import wsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  ext_cnt_q, ext_cnt_d;
  logic [31:0] len_acc_q, len_acc_d;
  logic        upper_nz_q, upper_nz_d;
  logic [31:0] mask_key_q, mask_key_d;
  logic [31:0] left_q, left_d;
  logic [1:0]  mask_idx_q, mask_idx_d;
  logic        bin_q, bin_d;
  logic [3:0]  head_q, head_d;

  logic [6:0]  len7;
  logic [3:0]  ext_total;
  logic [3:0]  cnt_inc;
  logic [3:0]  hs;
  logic        fits;
  logic        too_long;
  logic [31:0] left_dec;
  logic [7:0]  mask_byte;

  assign len7      = byte_i[6:0];
  assign ext_total = head_q - HeadShort;
  assign cnt_inc   = ext_cnt_q + 4'd1;
  assign hs        = head_q + MaskBytes;
  assign fits      = (len_acc_q >> LenCheckShift) == '0;
  assign too_long  = upper_nz_q || !fits;
  assign left_dec  = (left_q != '0) ? left_q - 32'd1 : left_q;

  always_comb begin
    case (mask_idx_q)
      2'd0:    mask_byte = mask_key_q[31:24];
      2'd1:    mask_byte = mask_key_q[23:16];
      2'd2:    mask_byte = mask_key_q[15:8];
      default: mask_byte = mask_key_q[7:0];
    endcase
  end

  // next state
  always_comb begin
    phase_d    = phase_q;
    ext_cnt_d  = ext_cnt_q;
    len_acc_d  = len_acc_q;
    upper_nz_d = upper_nz_q;
    mask_key_d = mask_key_q;
    left_d     = left_q;
    mask_idx_d = mask_idx_q;
    bin_d      = bin_q;
    head_d     = head_q;
    unique case (phase_q)
      PH_FIRST: begin
        if (byte_i == FirstText || byte_i == FirstBinary) begin
          bin_d      = (byte_i == FirstBinary);
          len_acc_d  = '0;
          upper_nz_d = 1'b0;
          ext_cnt_d  = '0;
          mask_key_d = '0;
          phase_d    = PH_LEN;
        end
      end
      PH_LEN: begin
        ext_cnt_d = '0;
        if (len7 == Len16Code) begin
          head_d  = Head16;
          phase_d = PH_EXT;
        end else if (len7 == Len64Code) begin
          head_d  = Head64;
          phase_d = PH_EXT;
        end else begin
          len_acc_d = {25'd0, len7};
          head_d    = HeadShort;
          phase_d   = PH_MASK;
        end
      end
      PH_EXT: begin
        // 64-bit form: first four bytes are the upper word, only checked for zero
        if (ext_total == Ext64Len && ext_cnt_q < UpperLen) begin
          if (byte_i != '0) upper_nz_d = 1'b1;
        end else begin
          len_acc_d = {len_acc_q[23:0], byte_i};
        end
        ext_cnt_d = cnt_inc;
        if (cnt_inc >= ext_total) begin
          ext_cnt_d = '0;
          phase_d   = PH_MASK;
        end
      end
      PH_MASK: begin
        mask_key_d = {mask_key_q[23:0], byte_i};
        ext_cnt_d  = cnt_inc;
        if (cnt_inc >= MaskBytes) begin
          ext_cnt_d  = '0;
          head_d     = hs;
          mask_idx_d = '0;
          if (too_long) begin
            phase_d = PH_FIRST;
          end else begin
            left_d  = len_acc_q;
            phase_d = (len_acc_q == '0) ? PH_FIRST : PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        mask_idx_d = mask_idx_q + 2'd1;
        left_d     = left_dec;
        if (left_dec == '0) phase_d = PH_FIRST;
      end
      default: phase_d = PH_FIRST;
    endcase
  end

  // result
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (phase_q)
      PH_FIRST: begin
        if (!(byte_i == FirstText || byte_i == FirstBinary)) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_BAD_FIRST;
          res_o.last  = 1'b1;
        end
      end
      PH_MASK: begin
        if (cnt_inc >= MaskBytes) begin
          res_valid_o       = 1'b1;
          res_o.header_size = hs;
          res_o.is_binary   = bin_q;
          if (too_long) begin
            res_o.kind = KIND_TOO_LONG;
            res_o.last = 1'b1;
          end else begin
            res_o.kind           = KIND_HEADER;
            res_o.payload_length = len_acc_q;
            res_o.packet_size    = {1'b0, len_acc_q} + {29'd0, hs};
            res_o.last           = (len_acc_q == '0);
          end
        end
      end
      PH_PAYLOAD: begin
        res_valid_o        = 1'b1;
        res_o.kind         = KIND_PAYLOAD;
        res_o.payload_byte = byte_i ^ mask_byte;
        res_o.is_binary    = bin_q;
        res_o.last         = (left_dec == '0);
      end
      default: res_valid_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_FIRST;
      ext_cnt_q  <= '0;
      len_acc_q  <= '0;
      upper_nz_q <= 1'b0;
      mask_key_q <= '0;
      left_q     <= '0;
      mask_idx_q <= '0;
      bin_q      <= 1'b0;
      head_q     <= '0;
    end else if (take_i) begin
      phase_q    <= phase_d;
      ext_cnt_q  <= ext_cnt_d;
      len_acc_q  <= len_acc_d;
      upper_nz_q <= upper_nz_d;
      mask_key_q <= mask_key_d;
      left_q     <= left_d;
      mask_idx_q <= mask_idx_d;
      bin_q      <= bin_d;
      head_q     <= head_d;
    end
  end

endmodule

>>> rtl/wsd_out_reg.sv
module wsd_out_reg import wsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  res_t        res_i,
  output logic        free_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output res_t        res_o
);

  logic vld_q, vld_d;
  res_t res_q, res_d;

  assign free_o = !vld_q || !out_stall_i;

  always_comb begin
    vld_d = load_i ? 1'b1 : (free_o ? 1'b0 : vld_q);
    res_d = load_i ? res_i : res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

>>> rtl/websocket_frame_deframer.sv
// Receive-side WebSocket deframer for single, unfragmented, masked frames. Bytes enter on
// in_byte_i with a valid/stall handshake, one word per clock at full rate: a byte is taken
// into an input register, decoded against the frame state, and any result is
// written to an output register, so throughput is one byte per clock as long as the
// output side is not stalled. A frame must open with 0x81 (final text) or
// 0x82 (final binary); any other opening byte yields a bad-first-byte word with last set and
// the block hunts for the next valid opener. After the length byte, the optional 16- or
// 64-bit extended length and the four mask key bytes, one header word gives payload length,
// header size and packet size (last is set for an empty frame). For 64-bit lengths the
// upper four bytes must be zero, otherwise a too-long word with last set replaces the
// header and the payload is not skipped. Each payload byte then comes out unmasked, the
// final one flagged with last. Header bytes before the fourth mask byte produce no output.
module websocket_frame_deframer import wsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  out_payload_byte_o,
  output logic [31:0] out_payload_length_o,
  output logic [3:0]  out_header_size_o,
  output logic [32:0] out_packet_size_o,
  output logic        out_is_binary_o,
  output logic        out_last_o
);

  logic       in_vld;
  logic [7:0] in_byte;
  logic       out_free;
  logic       take;
  logic       res_valid;
  res_t       res;
  res_t       out_res;

  // A buffered byte is decoded whenever the output register can take a word.
  assign take = in_vld && out_free;

  wsd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .in_stall_o (in_stall_o),
    .take_i     (take),
    .vld_o      (in_vld),
    .byte_o     (in_byte)
  );

  wsd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .byte_i      (in_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wsd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take && res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign out_kind_o           = out_res.kind;
  assign out_payload_byte_o   = out_res.payload_byte;
  assign out_payload_length_o = out_res.payload_length;
  assign out_header_size_o    = out_res.header_size;
  assign out_packet_size_o    = out_res.packet_size;
  assign out_is_binary_o      = out_res.is_binary;
  assign out_last_o           = out_res.last;

  // stall only while a byte is parked in the input register
  a_stall_needs_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld)
    else $error("input stalled with empty input register");

  // header word sizes add up
  a_packet_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_kind_o == KIND_HEADER) |->
      (out_packet_size_o == {1'b0, out_payload_length_o} + {29'd0, out_header_size_o}))
    else $error("packet size mismatch");

  // error words always close the frame
  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_kind_o == KIND_BAD_FIRST || out_kind_o == KIND_TOO_LONG)) |->
      out_last_o)
    else $error("error word without last");

endmodule
